### hdl/hss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_pkg: shared types, constants and ROM builders
// Sizes of the delay line and sine table, the MAC control word, and the
// elaboration-time generation of the Hilbert coefficient and quarter-sine ROMs.
// ----------------------------------------------------------------------------
package hss_pkg;

  localparam int TAPS            = 63;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QW              = 1 << SINE_TABLE_BITS;
  localparam int CENTER          = TAPS / 2;
  localparam int SAMPLE_W        = 16;
  localparam int COEF_W          = 18;
  localparam int PROD_W          = SAMPLE_W + COEF_W;
  localparam int ACC_W           = PROD_W + $clog2(TAPS);
  localparam int PTR_W           = $clog2(TAPS);
  localparam int QA_W            = SINE_TABLE_BITS + 1;

  localparam longint unsigned ONE_Q30    = 64'd1073741824;
  localparam longint unsigned PIHALF_Q30 = 64'd1686629713;
  localparam longint TWO_OVER_PI_Q30     = 64'sd683565276;
  localparam longint BLK_A_Q30           = 64'sd450971566;
  localparam longint BLK_C_Q30           = 64'sd85899346;
  localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_IM,
    DST_SR,
    DST_SI
  } dst_t;

  // one beat of work for the shared multiplier
  typedef struct packed {
    logic vld;
    logic clear;
    logic sub;
    dst_t dst;
  } mac_ctl_t;

  typedef logic signed [COEF_W-1:0] coef_rom_t [TAPS];
  typedef logic [SAMPLE_W-1:0] qsine_rom_t [QW+1];

  function automatic longint rshift(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // shift-and-subtract quotient, only used while building the ROMs
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor sine, degree 13, argument in 2^-32 turn, result Q30
  function automatic longint sine_q30(input logic [31:0] a);
    longint unsigned f;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    f = longint'(a[29:0]);
    if (a[30]) f = ONE_Q30 - f;
    x  = (f * PIHALF_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 156;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    if (s > ONE_Q30) s = ONE_Q30;
    return a[31] ? -longint'(s) : longint'(s);
  endfunction

  function automatic qsine_rom_t build_qsine();
    qsine_rom_t rom;
    longint s;
    longint q;
    for (int k = 0; k <= QW; k++) begin
      s = sine_q30(32'(k) << (30 - SINE_TABLE_BITS));
      q = (s + 64'sd16384) >>> 15;
      rom[k] = (q > 64'sd32767) ? 16'd32767 : 16'(q);
    end
    return rom;
  endfunction

  // Blackman-windowed Hilbert taps, Q1.17
  function automatic coef_rom_t build_coef();
    coef_rom_t rom;
    longint n;
    longint c1;
    longint c2;
    longint w;
    longint h;
    longint mag;
    logic [31:0] a1;
    logic [31:0] a2;
    for (int i = 0; i < TAPS; i++) begin
      n  = longint'(i - CENTER);
      a1 = 32'((longint'(i) << 32) / (TAPS - 1));
      a2 = a1 << 1;
      if ((n & 64'sd1) == 64'sd0) begin
        rom[i] = '0;
      end else begin
        c1  = sine_q30(a1 + QUARTER_TURN);
        c2  = sine_q30(a2 + QUARTER_TURN);
        w   = BLK_A_Q30 - rshift(c1, 1) + rshift(BLK_C_Q30 * c2, 30);
        mag = (n < 0) ? -n : n;
        h   = longint'(udiv(TWO_OVER_PI_Q30, mag));
        if (n < 0) h = -h;
        rom[i] = COEF_W'(rshift(h * w, 43));
      end
    end
    return rom;
  endfunction

  localparam coef_rom_t COEF_ROM = build_coef();

endpackage

### hdl/hss_delay_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_delay_mem: circular sample delay line
// One write and one registered read port; per-entry valid bits make
// entries not yet written since reset read as zero.
// ----------------------------------------------------------------------------
module hss_delay_mem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [hss_pkg::PTR_W-1:0]      waddr,
  input  logic signed [hss_pkg::SAMPLE_W-1:0] wdata,
  input  logic [hss_pkg::PTR_W-1:0]      raddr,
  output logic signed [hss_pkg::SAMPLE_W-1:0] rdata
);
  import hss_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [TAPS];
  logic [TAPS-1:0]            valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

endmodule

### hdl/hss_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_sine_rom: quarter-wave sine table
// First quadrant of sin, Q1.15, endpoint included, registered read.
// ----------------------------------------------------------------------------
module hss_sine_rom (
  input  logic                         clk,
  input  logic [hss_pkg::QA_W-1:0]     addr,
  output logic [hss_pkg::SAMPLE_W-1:0] q
);
  import hss_pkg::*;

  localparam qsine_rom_t QSINE = build_qsine();

  always_ff @(posedge clk) begin
    q <= QSINE[addr];
  end

endmodule

### hdl/hss_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_mac: shared multiply-accumulate unit
// Registered 16x18 signed product, then add or subtract into the
// accumulator; a tagged last beat raises done with its destination.
// ----------------------------------------------------------------------------
module hss_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  hss_pkg::mac_ctl_t                  ctl,
  input  logic signed [hss_pkg::SAMPLE_W-1:0] op_a,
  input  logic signed [hss_pkg::COEF_W-1:0]   op_b,
  output logic signed [hss_pkg::ACC_W-1:0]    acc,
  output logic                               done,
  output hss_pkg::dst_t                      done_dst
);
  import hss_pkg::*;

  logic signed [PROD_W-1:0] prod;
  mac_ctl_t                 ctl_p;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  prod_x;

  assign base   = ctl_p.clear ? '0 : acc;
  assign prod_x = ACC_W'(prod);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (ctl_p.vld) begin
      acc <= ctl_p.sub ? base - prod_x : base + prod_x;
    end
    done_dst <= ctl_p.dst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p <= '0;
      done  <= 1'b0;
    end else begin
      ctl_p <= ctl;
      done  <= ctl_p.vld && (ctl_p.dst != DST_NONE);
    end
  end

endmodule

### hdl/hilbert_ssb_frequency_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_ssb_frequency_shifter: Hilbert-transformer SSB frequency shifter
// Delay line plus Hilbert FIR forms the analytic signal, which is mixed
// with a quadrature oscillator on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  input    | in_valid / in_stall (out) | sample_in
//  output   | out_valid / out_stall (in)| analytic_real, analytic_imag,
//           |                           | shifted_real, shifted_imag
//  config   | cfg_valid / cfg_ready     | cfg_data (shift_step)
//
//  Each accepted sample runs one MAC beat per tap, then the four mixer
//  products; the multiply/accumulate pipeline drains after the FIR and
//  after the mixer, and the result then loads the output register.
//  in_stall is high from the accepted beat until the result moves to the
//  output register, which holds it while out_stall is high; the next sample
//  is taken meanwhile. Synchronous reset clears control, delay-line valid
//  bits, write pointer, phase and step; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hilbert_ssb_frequency_shifter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [hss_pkg::SAMPLE_W-1:0] sample_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [hss_pkg::SAMPLE_W-1:0] analytic_real,
  output logic signed [hss_pkg::SAMPLE_W-1:0] analytic_imag,
  output logic signed [hss_pkg::SAMPLE_W-1:0] shifted_real,
  output logic signed [hss_pkg::SAMPLE_W-1:0] shifted_imag,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [31:0]                        cfg_data
);
  import hss_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIR,
    ST_WAIT_FIR,
    ST_MIX,
    ST_WAIT_MIX,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    ASEL_MEM,
    ASEL_RE,
    ASEL_IM
  } asel_t;

  typedef enum logic [1:0] {
    BSEL_COEF,
    BSEL_SIN,
    BSEL_COS
  } bsel_t;

  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] v,
    input int                      sh
  );
    logic signed [ACC_W:0] u;
    logic signed [ACC_W:0] r;
    u = $signed({v[ACC_W-1], v}) + $signed((ACC_W+1)'(1) << (sh - 1));
    r = u >>> sh;
    if (r > $signed((ACC_W+1)'(32767))) return 16'sd32767;
    if (r < -$signed((ACC_W+1)'(32768))) return -16'sd32768;
    return SAMPLE_W'(r);
  endfunction

  state_t               state;
  logic [PTR_W-1:0]     cnt;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W-1:0]     wp;
  logic [31:0]          osc_phase;
  logic [31:0]          shift_step;

  mac_ctl_t             s1_ctl;
  asel_t                s1_asel;
  bsel_t                s1_bsel;
  logic                 s1_center;
  logic                 s1_take_sin;
  logic                 s1_take_cos;
  logic                 s1_neg;

  logic signed [COEF_W-1:0]   coef_q;
  logic signed [SAMPLE_W-1:0] re_q;
  logic signed [SAMPLE_W-1:0] im_q;
  logic signed [SAMPLE_W-1:0] sr_q;
  logic signed [SAMPLE_W-1:0] si_q;
  logic signed [SAMPLE_W-1:0] sin_v;
  logic signed [SAMPLE_W-1:0] cos_v;

  logic                       accept;
  logic signed [SAMPLE_W-1:0] mem_rdata;
  logic [SAMPLE_W-1:0]        rom_q;
  logic [1:0]                 lut_quad;
  logic [SINE_TABLE_BITS-1:0] lut_k;
  logic [QA_W-1:0]            rom_addr;

  logic signed [SAMPLE_W-1:0] op_a;
  logic signed [COEF_W-1:0]   op_b;
  logic signed [ACC_W-1:0]    acc;
  logic                       mac_done;
  dst_t                       mac_dst;
  logic                       out_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // sine on the first FIR beat, cosine (quadrant + 1) on the second
  assign lut_quad = osc_phase[31:30] + ((cnt == '0) ? 2'd0 : 2'd1);
  assign lut_k    = osc_phase[29 -: SINE_TABLE_BITS];
  assign rom_addr = lut_quad[0] ? QA_W'(QW) - {1'b0, lut_k} : {1'b0, lut_k};

  hss_delay_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (accept),
    .waddr (wp),
    .wdata (sample_in),
    .raddr (rd_ptr),
    .rdata (mem_rdata)
  );

  hss_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

  always_comb begin
    unique case (s1_asel)
      ASEL_MEM: op_a = mem_rdata;
      ASEL_RE:  op_a = re_q;
      ASEL_IM:  op_a = im_q;
      default:  op_a = re_q;
    endcase
    unique case (s1_bsel)
      BSEL_COEF: op_b = coef_q;
      BSEL_SIN:  op_b = {{(COEF_W-SAMPLE_W){sin_v[SAMPLE_W-1]}}, sin_v};
      BSEL_COS:  op_b = {{(COEF_W-SAMPLE_W){cos_v[SAMPLE_W-1]}}, cos_v};
      default:   op_b = coef_q;
    endcase
  end

  hss_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (s1_ctl),
    .op_a     (op_a),
    .op_b     (op_b),
    .acc      (acc),
    .done     (mac_done),
    .done_dst (mac_dst)
  );

  // sequencer, pointers, oscillator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      rd_ptr      <= '0;
      wp          <= '0;
      osc_phase   <= '0;
      shift_step  <= '0;
      s1_ctl      <= '0;
      s1_asel     <= ASEL_MEM;
      s1_bsel     <= BSEL_COEF;
      s1_center   <= 1'b0;
      s1_take_sin <= 1'b0;
      s1_take_cos <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        shift_step <= cfg_data;
      end
      s1_ctl      <= '0;
      s1_center   <= 1'b0;
      s1_take_sin <= 1'b0;
      s1_take_cos <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rd_ptr    <= wp;
            wp        <= (wp == PTR_W'(TAPS - 1)) ? '0 : wp + 1'b1;
            osc_phase <= osc_phase + shift_step;
            cnt       <= '0;
            state     <= ST_FIR;
          end
        end
        ST_FIR: begin
          s1_ctl.vld  <= 1'b1;
          s1_ctl.clear <= (cnt == '0);
          s1_ctl.sub  <= 1'b0;
          s1_ctl.dst  <= (cnt == PTR_W'(TAPS - 1)) ? DST_IM : DST_NONE;
          s1_asel     <= ASEL_MEM;
          s1_bsel     <= BSEL_COEF;
          s1_center   <= (cnt == PTR_W'(CENTER));
          s1_take_sin <= (cnt == '0);
          s1_take_cos <= (cnt == PTR_W'(1));
          rd_ptr      <= (rd_ptr == '0) ? PTR_W'(TAPS - 1) : rd_ptr - 1'b1;
          if (cnt == PTR_W'(TAPS - 1)) begin
            state <= ST_WAIT_FIR;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_WAIT_FIR: begin
          if (mac_done && mac_dst == DST_IM) begin
            cnt   <= '0;
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          s1_ctl.vld <= 1'b1;
          unique case (cnt[1:0])
            2'd0: begin
              s1_ctl.clear <= 1'b1;
              s1_ctl.sub   <= 1'b0;
              s1_ctl.dst   <= DST_NONE;
              s1_asel      <= ASEL_RE;
              s1_bsel      <= BSEL_COS;
            end
            2'd1: begin
              s1_ctl.clear <= 1'b0;
              s1_ctl.sub   <= 1'b1;
              s1_ctl.dst   <= DST_SR;
              s1_asel      <= ASEL_IM;
              s1_bsel      <= BSEL_SIN;
            end
            2'd2: begin
              s1_ctl.clear <= 1'b1;
              s1_ctl.sub   <= 1'b0;
              s1_ctl.dst   <= DST_NONE;
              s1_asel      <= ASEL_RE;
              s1_bsel      <= BSEL_SIN;
            end
            default: begin
              s1_ctl.clear <= 1'b0;
              s1_ctl.sub   <= 1'b0;
              s1_ctl.dst   <= DST_SI;
              s1_asel      <= ASEL_IM;
              s1_bsel      <= BSEL_COS;
            end
          endcase
          if (cnt[1:0] == 2'd3) begin
            state <= ST_WAIT_MIX;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_WAIT_MIX: begin
          if (mac_done && mac_dst == DST_SI) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            analytic_real <= re_q;
            analytic_imag <= im_q;
            shifted_real  <= sr_q;
            shifted_imag  <= si_q;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath captures
  always_ff @(posedge clk) begin
    if (state == ST_FIR) begin
      coef_q <= COEF_ROM[cnt];
      s1_neg <= lut_quad[1];
    end
    if (s1_center) begin
      re_q <= mem_rdata;
    end
    if (s1_take_sin) begin
      sin_v <= s1_neg ? -$signed(rom_q) : $signed(rom_q);
    end
    if (s1_take_cos) begin
      cos_v <= s1_neg ? -$signed(rom_q) : $signed(rom_q);
    end
    if (mac_done) begin
      unique case (mac_dst)
        DST_IM:  im_q <= round_sat(acc, 17);
        DST_SR:  sr_q <= round_sat(acc, 15);
        DST_SI:  si_q <= round_sat(acc, 15);
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a sample is in flight");

  a_im_in_wait: assert property (@(posedge clk) disable iff (rst)
    (mac_done && mac_dst == DST_IM) |-> (state == ST_WAIT_FIR))
    else $error("FIR sum finished outside its wait state");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("output beat raised without a finished sample");

  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    (wp <= PTR_W'(TAPS - 1)) && (rd_ptr <= PTR_W'(TAPS - 1)))
    else $error("delay line pointer out of range");
`endif

endmodule

### tb/sv/tb_hilbert_ssb_frequency_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hilbert_ssb_frequency_shifter: self-checking bench for the SSB shifter
// Drives audio samples through the valid/stall input, predicts the analytic
// pair and the mixed outputs with an independent fixed-point model (own
// coefficient and sine tables), and compares every output beat in order.
// Covers sample extremes, phase-step extremes and wrap, full-scale saturation
// bursts, long output back-pressure and randomized idling on both sides.
// ----------------------------------------------------------------------------
module tb_hilbert_ssb_frequency_shifter;

  localparam int NTAPS     = hss_pkg::TAPS;
  localparam int MID_TAP   = NTAPS / 2;
  localparam int SINE_BITS = hss_pkg::SINE_TABLE_BITS;
  localparam int QW_LEN    = 1 << SINE_BITS;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 200;
  localparam longint unsigned UNIT_Q30 = 64'd1073741824;

  typedef struct {
    logic signed [15:0] analytic_real;
    logic signed [15:0] analytic_imag;
    logic signed [15:0] shifted_real;
    logic signed [15:0] shifted_imag;
  } shift_result_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] analytic_real;
  logic signed [15:0] analytic_imag;
  logic signed [15:0] shifted_real;
  logic signed [15:0] shifted_imag;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  // predictor state
  int tap_coef [NTAPS];
  int qsine_tbl [QW_LEN+1];
  int line_mem [NTAPS];
  int wr_ptr;
  logic [31:0] phase_acc;
  logic [31:0] step_reg;
  shift_result_t pending_shifts [$];
  shift_result_t oldest_expected;

  int fail_count = 0;
  int idle_cycles = 0;
  int gap_pct;
  int stall_pct;
  int hold_len;
  int hold_seq;
  int hold_seen = 0;
  int hold_left = 0;

  hilbert_ssb_frequency_shifter dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_in     (sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .analytic_real (analytic_real),
    .analytic_imag (analytic_imag),
    .shifted_real  (shifted_real),
    .shifted_imag  (shifted_imag),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model --

  // Taylor sine, angle in 2^-32 turn, Q30 result
  function automatic longint sine_turn_q30(input logic [31:0] ang);
    longint unsigned divs [6];
    longint unsigned frac;
    longint unsigned x;
    longint unsigned sq;
    longint unsigned poly;
    longint unsigned mag;
    divs = '{156, 110, 72, 42, 20, 6};
    frac = 64'(ang[29:0]);
    if (ang[30]) frac = UNIT_Q30 - frac;
    x = (frac * 64'd1686629713) >> 30;
    sq = (x * x) >> 30;
    poly = UNIT_Q30;
    for (int k = 0; k < 6; k++) poly = UNIT_Q30 - ((sq * poly) >> 30) / divs[k];
    mag = (x * poly) >> 30;
    if (mag > UNIT_Q30) mag = UNIT_Q30;
    return ang[31] ? -longint'(mag) : longint'(mag);
  endfunction

  // round half up: floor((v + 2^(sh-1)) / 2^sh)
  function automatic longint round_half(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic longint osc_lookup(input logic [31:0] ph);
    logic [31:0] idx;
    int k;
    longint v;
    idx = ph >> (30 - SINE_BITS);
    k = int'(idx & (QW_LEN - 1));
    v = idx[SINE_BITS] ? qsine_tbl[QW_LEN - k] : qsine_tbl[k];
    return idx[SINE_BITS+1] ? -v : v;
  endfunction

  task automatic build_tables();
    longint s;
    longint q;
    longint c1;
    longint c2;
    longint w;
    longint h;
    int n;
    logic [31:0] a1;
    logic [31:0] a2;
    for (int k = 0; k <= QW_LEN; k++) begin
      s = sine_turn_q30(32'(k) << (30 - SINE_BITS));
      q = (s + 16384) >>> 15;
      qsine_tbl[k] = (q > 32767) ? 32767 : int'(q);
    end
    // Blackman-windowed Hilbert taps, odd offsets from center only
    for (int i = 0; i < NTAPS; i++) begin
      n = i - MID_TAP;
      if (n % 2 == 0) begin
        tap_coef[i] = 0;
      end else begin
        a1 = 32'((longint'(i) << 32) / (NTAPS - 1));
        a2 = a1 << 1;
        c1 = sine_turn_q30(a1 + hss_pkg::QUARTER_TURN);
        c2 = sine_turn_q30(a2 + hss_pkg::QUARTER_TURN);
        w = 64'sd450971566 - round_half(c1, 1) + round_half(64'sd85899346 * c2, 30);
        h = 64'sd683565276 / ((n < 0) ? -n : n);
        if (n < 0) h = -h;
        tap_coef[i] = int'(round_half(h * w, 43));
      end
    end
    for (int i = 0; i < NTAPS; i++) line_mem[i] = 0;
    wr_ptr = 0;
    phase_acc = '0;
    step_reg = '0;
  endtask

  task automatic predict_shift(input logic signed [15:0] x);
    longint acc;
    longint re;
    longint im;
    longint sn;
    longint cs;
    shift_result_t r;
    line_mem[wr_ptr] = x;
    acc = 0;
    for (int i = 0; i < NTAPS; i++)
      acc += longint'(line_mem[(wr_ptr + NTAPS - i) % NTAPS]) * tap_coef[i];
    im = clip16(round_half(acc, 17));
    re = line_mem[(wr_ptr + NTAPS - MID_TAP) % NTAPS];
    wr_ptr = (wr_ptr + 1) % NTAPS;
    phase_acc = phase_acc + step_reg;
    sn = osc_lookup(phase_acc);
    cs = osc_lookup(phase_acc + hss_pkg::QUARTER_TURN);
    r.analytic_real = 16'(re);
    r.analytic_imag = 16'(im);
    r.shifted_real  = clip16(round_half(re * cs - im * sn, 15));
    r.shifted_imag  = clip16(round_half(re * sn + im * cs, 15));
    pending_shifts.push_back(r);
  endtask

  // --------------------------------------------------------------- drivers --

  task automatic send_sample(input logic signed [15:0] x);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (in_stall);
    predict_shift(x);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_shifts.size() != 0) @(posedge clk);
  endtask

  // only called with nothing in flight
  task automatic write_shift_step(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_reg = v;
  endtask

  // output back-pressure: random, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_shifts.size() == 0) begin
        $error("output beat with no sample pending");
        fail_count++;
      end else begin
        oldest_expected = pending_shifts.pop_front();
        if (analytic_real !== oldest_expected.analytic_real) begin
          $error("analytic_real expected %0d actual %0d",
                 oldest_expected.analytic_real, analytic_real);
          fail_count++;
        end
        if (analytic_imag !== oldest_expected.analytic_imag) begin
          $error("analytic_imag expected %0d actual %0d",
                 oldest_expected.analytic_imag, analytic_imag);
          fail_count++;
        end
        if (shifted_real !== oldest_expected.shifted_real) begin
          $error("shifted_real expected %0d actual %0d",
                 oldest_expected.shifted_real, shifted_real);
          fail_count++;
        end
        if (shifted_imag !== oldest_expected.shifted_imag) begin
          $error("shifted_imag expected %0d actual %0d",
                 oldest_expected.shifted_imag, shifted_imag);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_hilbert_ssb_frequency_shifter NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ----------------------------------------------------------------- tests --

  task automatic test_reset_state();
    write_shift_step(32'h0);
    repeat (3) send_sample(16'($urandom));
    wait_results_done();
  endtask

  task automatic test_sample_extremes();
    logic signed [15:0] vals [8];
    vals = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
             16'sh0001, 16'sh5555, 16'shaaaa, 16'sh4000};
    gap_pct = 10;
    stall_pct = 30;
    write_shift_step(32'h1234_5678);
    foreach (vals[i]) send_sample(vals[i]);
    wait_results_done();
  endtask

  // step extremes exercise phase wrap in both directions
  task automatic test_step_extremes();
    logic [31:0] steps [5];
    steps = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h4000_0000};
    foreach (steps[i]) begin
      write_shift_step(steps[i]);
      repeat (3) send_sample(16'($urandom));
      wait_results_done();
    end
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    hold_len = 600;
    hold_seq++;
    repeat (10) send_sample(16'($urandom));
    wait_results_done();
    repeat (5) send_sample(16'($urandom));
    wait_results_done();
  endtask

  task automatic run_segments(input int target);
    int sent;
    int seg;
    int len;
    int pol;
    int cf;
    logic signed [15:0] x;
    sent = 0;
    while (sent < target) begin
      seg = $urandom_range(3);
      len = (seg == 2) ? NTAPS : $urandom_range(10, 40);
      pol = $urandom_range(1);
      for (int t = 0; t < len; t++) begin
        case (seg)
          0: x = 16'($urandom);
          1: x = 16'($signed($urandom_range(512)) - 256);
          2: begin
            // full-scale samples matched to tap signs: drives the FIR into saturation
            cf = tap_coef[NTAPS - 1 - t];
            if (cf == 0) x = 16'($urandom);
            else x = ((cf > 0) ^ (pol == 1)) ? 16'sh7fff : 16'sh8000;
          end
          default: begin
            case ($urandom_range(3))
              0: x = 16'sh7fff;
              1: x = 16'sh8000;
              2: x = 16'sh0000;
              default: x = 16'($urandom);
            endcase
          end
        endcase
        send_sample(x);
      end
      sent += len;
    end
  endtask

  task automatic test_random_traffic();
    int gaps [3];
    int stalls [3];
    gaps = '{25, 82, 0};
    stalls = '{82, 25, 0};
    for (int ph = 0; ph < 3; ph++) begin
      wait_results_done();
      gap_pct = gaps[ph];
      stall_pct = stalls[ph];
      if (ph == 1) write_shift_step(32'($urandom_range(65535)));
      else write_shift_step($urandom);
      run_segments(150);
    end
  endtask

  initial begin
    gap_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    hold_seq = 0;
    build_tables();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_sample_extremes();
    test_step_extremes();
    test_backpressure();
    test_random_traffic();
    wait_results_done();
    gap_pct = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_shifts.size() == 0) begin
      $display("tb_hilbert_ssb_frequency_shifter OK");
    end else begin
      $display("tb_hilbert_ssb_frequency_shifter NOT OK");
    end
    $finish;
  end

endmodule
